// ===== hw/rtl/hmmf_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none
package hmmf_pkg;
  localparam int NUM_STATES = 32;
  localparam int IDX_W = $clog2(NUM_STATES);
  localparam int CNT_W = 6;
  localparam logic [31:0] ONE_Q31 = 32'h8000_0000;
  localparam logic [39:0] SUM_MAX = 40'hFF_FFFF_FFFF;
  localparam logic [0:0] REG_START_MODE = 1'b0;
  localparam logic [0:0] REG_FIRST_ONLY = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE, ST_MUL1, ST_MUL2, ST_DIV, ST_EMIT_RD, ST_EMIT_MUL, ST_EMIT_OUT
  } state_t;

  function automatic logic [31:0] clamp_q31(input logic [32:0] v);
    logic [31:0] r;
    r = (v > {1'b0, ONE_Q31}) ? ONE_Q31 : v[31:0];
    return r;
  endfunction
endpackage
`default_nettype wire

// ===== hw/rtl/hmmf_ram.sv =====
`timescale 1ns / 1ps
`default_nettype none
module hmmf_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 32
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/hmmf_div.sv =====
`timescale 1ns / 1ps
`default_nettype none
// restoring divider: 2^51 + sum/2 over sum, one quotient bit per cycle
module hmmf_div (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  input  wire logic [39:0] divisor,
  output logic             done,
  output logic [31:0]      scale,
  output logic             sat
);
  logic [52:0] num_r, num_nxt;
  logic [40:0] rem_r, rem_nxt;
  logic [52:0] quo_r, quo_nxt;
  logic [5:0]  cnt_r, cnt_nxt;
  logic        busy_r, busy_nxt;
  logic [39:0] den_r, den_nxt;
  logic [41:0] trial;

  always_comb begin
    num_nxt = num_r; rem_nxt = rem_r; quo_nxt = quo_r;
    cnt_nxt = cnt_r; busy_nxt = busy_r; den_nxt = den_r;
    trial = '0;
    done = 1'b0;
    if (start) begin
      num_nxt = (53'd1 << 51) + {14'd0, divisor[39:1]};
      rem_nxt = '0; quo_nxt = '0; cnt_nxt = 6'd53;
      busy_nxt = 1'b1; den_nxt = divisor;
    end else if (busy_r) begin
      trial = {rem_r, num_r[52]} - {2'b0, den_r};
      if (!trial[41]) begin
        rem_nxt = trial[40:0]; quo_nxt = {quo_r[51:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[39:0], num_r[52]}; quo_nxt = {quo_r[51:0], 1'b0};
      end
      num_nxt = {num_r[51:0], 1'b0};
      cnt_nxt = cnt_r - 6'd1;
      if (cnt_r == 6'd1) begin
        busy_nxt = 1'b0;
      end
    end
    done = busy_r && !busy_nxt && !start;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0; cnt_r <= '0;
    end else begin
      busy_r <= busy_nxt; cnt_r <= cnt_nxt;
    end
    num_r <= num_nxt; rem_r <= rem_nxt; quo_r <= quo_nxt; den_r <= den_nxt;
  end

  always_comb begin
    sat = (den_r == 40'd0) || (quo_nxt[52:32] != '0);
    scale = sat ? 32'hFFFF_FFFF : quo_nxt[31:0];
  end
endmodule
`default_nettype wire

// ===== hw/rtl/hmm_forward_scaled_haploid_unit.sv =====
`timescale 1ns / 1ps
`default_nettype none
// Scaled forward recursion unit, one HMM grid column at a time.
// Input channel in_*: one state element per item (emission, ref_weight,
// stay/switch rates, first-column flag in tuser, last element as tlast).
// First-column items pass through accept, multiply and accumulate (into the
// 40-bit saturating column sum); later-column items hold MUL2 longer to
// form emission times the inner sum. Raw values are stored in a
// raw-alpha RAM at the element index.
// On the closing element a 53-step restoring divider forms the scale,
// then each of the K results needs a RAM read, the scale multiply and an
// output state that holds through any output stall. Normalized values are
// written back to the previous-alpha RAM as they are emitted.
// The output holds while out_tready is low; no new item is accepted until
// the column is fully delivered. Reset (rst_n low, synchronous) clears
// counters, sum, first_done and both config bits; RAM contents stay
// undefined until written.
// cfg_we writes register cfg_addr: 0 start_mode, 1 first_column_only.
module hmm_forward_scaled_haploid_unit (
  input  wire logic         clk,
  input  wire logic         rst_n,
  input  wire logic         cfg_we,
  input  wire logic         cfg_addr,
  input  wire logic         cfg_wdata,
  input  wire logic         in_tvalid,
  output logic              in_tready,
  input  wire logic [127:0] in_tdata,  // emission, ref_weight, stay_rate, switch_rate
  input  wire logic         in_tuser,  // first_column
  input  wire logic         in_tlast,  // last_element
  output logic              out_tvalid,
  input  wire logic         out_tready,
  output logic [71:0]       out_tdata, // state_index, alpha_value, scale, zero pad
  output logic              out_tuser, // scale_saturated
  output logic              out_tlast  // last_of_column
);
  localparam int IW = hmmf_pkg::IDX_W;

  hmmf_pkg::state_t st_r, st_nxt;
  logic start_mode_r, first_only_r, first_done_r;
  logic [39:0] sum_r;
  logic [hmmf_pkg::CNT_W-1:0] cnt_r;
  logic [IW-1:0] n_last_r, k_r;
  logic [31:0] em_r, ref_r, stay_r, sw_r;
  logic first_r, close_r, col_first_r;
  logic [63:0] p1_r, p2_r;
  logic [31:0] prev_q;
  logic [31:0] raw_q;
  logic [63:0] am_r;
  logic [31:0] scale_r;
  logic sat_r;
  logic [31:0] raw_val;
  logic [32:0] inner_sum;
  logic [31:0] inner;
  logic [40:0] sum_add;
  logic [43:0] alpha_rnd;
  logic [31:0] alpha;
  logic div_done, div_sat;
  logic [31:0] div_scale;
  logic acc, ign, k_full;
  logic [IW-1:0] k_in;

  assign in_tready = (st_r == hmmf_pkg::ST_IDLE);
  assign acc = in_tvalid && in_tready;
  assign ign = first_only_r && !in_tuser;
  assign k_full = (cnt_r >= hmmf_pkg::CNT_W'(hmmf_pkg::NUM_STATES - 1));
  assign k_in = k_full ? IW'(hmmf_pkg::NUM_STATES - 1) : cnt_r[IW-1:0];

  // element datapath
  always_comb begin
    inner_sum = {1'b0, p1_r[62:31]} + {1'b0, p2_r[62:31]};
    inner = hmmf_pkg::clamp_q31(inner_sum);
    if (first_r) raw_val = start_mode_r ? ref_r : p1_r[62:31];
    else raw_val = p2_r[62:31];
    sum_add = {1'b0, sum_r} + {9'd0, raw_val};
  end

  // prev read is zero before the first column completes
  logic [31:0] prev_v;
  assign prev_v = first_done_r ? prev_q : 32'd0;

  always_ff @(posedge clk) begin
    if (acc) begin
      em_r <= hmmf_pkg::clamp_q31({1'b0, in_tdata[31:0]});
      ref_r <= hmmf_pkg::clamp_q31({1'b0, in_tdata[63:32]});
      stay_r <= hmmf_pkg::clamp_q31({1'b0, in_tdata[95:64]});
      sw_r <= hmmf_pkg::clamp_q31({1'b0, in_tdata[127:96]});
      first_r <= in_tuser;
      close_r <= in_tlast || k_full;
    end
    if (st_r == hmmf_pkg::ST_MUL1) begin
      if (first_r) p1_r <= {32'd0, ref_r} * {32'd0, em_r};
      else p1_r <= {32'd0, stay_r} * {32'd0, prev_v};
      p2_r <= {32'd0, sw_r} * {32'd0, ref_r};
    end
    if (st_r == hmmf_pkg::ST_MUL2 && !first_r) p2_r <= {32'd0, em_r} * {32'd0, inner};
    if (st_r == hmmf_pkg::ST_EMIT_MUL) am_r <= {32'd0, raw_q} * {32'd0, scale_r};
    if (div_done) begin
      scale_r <= div_scale; sat_r <= div_sat;
    end
  end

  // ST_MUL2 uses p2 from MUL1 for the inner sum; mul2b_r marks its extra pass
  logic mul2b_r;

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      hmmf_pkg::ST_IDLE:     if (acc && !ign) st_nxt = hmmf_pkg::ST_MUL1;
      hmmf_pkg::ST_MUL1:     st_nxt = hmmf_pkg::ST_MUL2;
      hmmf_pkg::ST_MUL2:     if (first_r || mul2b_r)
                               st_nxt = close_r ? hmmf_pkg::ST_DIV : hmmf_pkg::ST_IDLE;
      hmmf_pkg::ST_DIV:      if (div_done) st_nxt = hmmf_pkg::ST_EMIT_RD;
      hmmf_pkg::ST_EMIT_RD:  st_nxt = hmmf_pkg::ST_EMIT_MUL;
      hmmf_pkg::ST_EMIT_MUL: st_nxt = hmmf_pkg::ST_EMIT_OUT;
      hmmf_pkg::ST_EMIT_OUT: if (out_tready)
                               st_nxt = (k_r == n_last_r) ? hmmf_pkg::ST_IDLE
                                                          : hmmf_pkg::ST_EMIT_RD;
      default:               st_nxt = hmmf_pkg::ST_IDLE;
    endcase
  end

  logic commit, div_go;
  always_comb begin
    commit = (st_r == hmmf_pkg::ST_MUL2) && (first_r || mul2b_r);
    div_go = commit && close_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= hmmf_pkg::ST_IDLE;
      start_mode_r <= 1'b0; first_only_r <= 1'b0; first_done_r <= 1'b0;
      sum_r <= '0; cnt_r <= '0; mul2b_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we && cfg_addr == hmmf_pkg::REG_START_MODE) start_mode_r <= cfg_wdata;
      if (cfg_we && cfg_addr == hmmf_pkg::REG_FIRST_ONLY) first_only_r <= cfg_wdata;
      mul2b_r <= (st_r == hmmf_pkg::ST_MUL2) && !first_r && !mul2b_r;
      if (commit) begin
        sum_r <= sum_add[40] ? hmmf_pkg::SUM_MAX : sum_add[39:0];
        cnt_r <= close_r ? '0 : cnt_r + hmmf_pkg::CNT_W'(1);
      end
      if (st_r == hmmf_pkg::ST_DIV && div_done) sum_r <= '0;
      if (st_r == hmmf_pkg::ST_EMIT_OUT && out_tready && k_r == n_last_r && col_first_r)
        first_done_r <= 1'b1;
    end
  end

  // element index on accept; after close it walks the raw RAM for emission
  always_ff @(posedge clk) begin
    if (div_go) begin
      n_last_r <= k_r; col_first_r <= first_r;
    end
    if (acc) k_r <= k_in;
    else if (div_done) k_r <= '0;
    else if (st_r == hmmf_pkg::ST_EMIT_OUT && out_tready) k_r <= k_r + IW'(1);
  end

  // MUL2 holds longer on later columns: p2 replaced by em*inner
  logic [31:0] raw_w;
  assign raw_w = raw_val;

  // raw * scale is up to 64 bits; round at bit 19, then clamp to one
  always_comb begin
    alpha_rnd = am_r[63:20] + {43'd0, am_r[19]};
    alpha = (alpha_rnd > {12'd0, hmmf_pkg::ONE_Q31}) ? hmmf_pkg::ONE_Q31 : alpha_rnd[31:0];
  end

  hmmf_ram #(.WIDTH(32), .DEPTH(hmmf_pkg::NUM_STATES)) u_raw (
    .clk(clk), .we(commit), .waddr(k_r), .wdata(raw_w),
    .raddr(k_r), .rdata(raw_q)
  );

  hmmf_ram #(.WIDTH(32), .DEPTH(hmmf_pkg::NUM_STATES)) u_prev (
    .clk(clk), .we(st_r == hmmf_pkg::ST_EMIT_OUT && out_tready),
    .waddr(k_r), .wdata(alpha),
    .raddr(acc ? k_in : k_r), .rdata(prev_q)
  );

  hmmf_div u_div (
    .clk(clk), .rst_n(rst_n), .start(div_go), .divisor(sum_add[40] ? hmmf_pkg::SUM_MAX
                                                        : sum_add[39:0]),
    .done(div_done), .scale(div_scale), .sat(div_sat)
  );

  assign out_tvalid = (st_r == hmmf_pkg::ST_EMIT_OUT);
  assign out_tdata = {2'd0, scale_r, alpha, 6'(k_r)};
  assign out_tuser = sat_r;
  assign out_tlast = (k_r == n_last_r);

  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(k_r))
    else $error("result dropped under stall");
  a_noacc: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> !in_tready) else $error("accept during emit");
  a_divdone: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> st_r == hmmf_pkg::ST_DIV) else $error("stray divide done");
endmodule
`default_nettype wire

// ===== sim/hmm_forward_scaled_haploid_unit_tb.sv =====
`timescale 1ns / 1ps

typedef struct {
  bit [5:0]  idx;
  bit [31:0] alpha;
  bit [31:0] scale;
  bit        sat;
  bit        last;
} alpha_result_t;

// Column-level predictor: keeps its own copy of the forward state and the
// expected normalized values of every closed column.
class alpha_scoreboard;
  localparam int N = hmmf_pkg::NUM_STATES;
  localparam longint unsigned ONE = 64'h8000_0000;
  localparam longint unsigned SUM_CAP = 64'hFF_FFFF_FFFF;

  bit [31:0] prev_alpha[N];
  bit [31:0] raw_val[N];
  longint unsigned col_sum;
  int count;
  bit first_done;
  int written_n;  // entries of prev_alpha written so far
  bit start_mode;
  bit first_only;
  alpha_result_t pending_q[$];
  int errors;

  function longint unsigned clamp1(longint unsigned v);
    return (v > ONE) ? ONE : v;
  endfunction

  function longint unsigned mulq(longint unsigned a, longint unsigned b);
    return (a * b) >> 31;
  endfunction

  function bit ignores(bit first);
    return first_only && !first;
  endfunction

  function void note_item(bit [31:0] em_i, bit [31:0] rf_i, bit [31:0] st_i,
                          bit [31:0] sw_i, bit first, bit last);
    longint unsigned em, rf, st, sw, raw, prv, inner, q, scl, a;
    bit sat;
    int k;
    alpha_result_t r;
    em = clamp1(em_i);
    rf = clamp1(rf_i);
    st = clamp1(st_i);
    sw = clamp1(sw_i);
    if (ignores(first)) return;
    k = (count >= N) ? N - 1 : count;
    if (first) begin
      raw = start_mode ? rf : mulq(rf, em);
    end else begin
      prv = first_done ? prev_alpha[k] : 0;
      inner = clamp1(mulq(st, prv) + mulq(sw, rf));
      raw = mulq(em, inner);
    end
    raw_val[k] = raw[31:0];
    col_sum += raw;
    if (col_sum > SUM_CAP) col_sum = SUM_CAP;
    if (!last && k < N - 1) begin
      count = k + 1;
      return;
    end
    // column closes: scale = round(2^51 / sum), saturating
    sat = 0;
    if (col_sum == 0) begin
      scl = 64'hFFFF_FFFF;
      sat = 1;
    end else begin
      q = ((64'd1 << 51) + (col_sum >> 1)) / col_sum;
      if (q > 64'hFFFF_FFFF) begin
        scl = 64'hFFFF_FFFF;
        sat = 1;
      end else begin
        scl = q;
      end
    end
    for (int i = 0; i <= k; i++) begin
      a = clamp1((longint'(raw_val[i]) * scl + (64'd1 << 19)) >> 20);
      prev_alpha[i] = a[31:0];
      r.idx = i[5:0];
      r.alpha = a[31:0];
      r.scale = scl[31:0];
      r.sat = sat;
      r.last = (i == k);
      pending_q = {pending_q, r};
    end
    if (k + 1 > written_n) written_n = k + 1;
    if (first) first_done = 1;
    col_sum = 0;
    count = 0;
  endfunction

  function void check_result(bit [5:0] idx, bit [31:0] alpha, bit [31:0] scale,
                             bit sat, bit last);
    alpha_result_t e;
    if (pending_q.size() == 0) begin
      errors++;
      if (errors <= 10)
        $display("unexpected item: idx %0d alpha %h scale %h", idx, alpha, scale);
      return;
    end
    e = pending_q.pop_front();
    if (e.idx != idx || e.alpha != alpha || e.scale != scale || e.sat != sat ||
        e.last != last) begin
      errors++;
      if (errors <= 10)
        $display({"mismatch: exp idx %0d alpha %h scale %h sat %b last %b",
                  " / got idx %0d alpha %h scale %h sat %b last %b"},
                 e.idx, e.alpha, e.scale, e.sat, e.last, idx, alpha, scale, sat, last);
    end
  endfunction
endclass

module hmm_forward_scaled_haploid_unit_tb;
  localparam int CYCLE_LIMIT = 400000;

  logic         clk;
  logic         rst_n;
  logic         cfg_we;
  logic         cfg_addr;
  logic         cfg_wdata;
  logic         in_tvalid;
  logic         in_tready;
  logic [127:0] in_tdata;  // emission, ref_weight, stay_rate, switch_rate
  logic         in_tuser;  // first_column
  logic         in_tlast;  // last_element
  logic         out_tvalid;
  logic         out_tready;
  logic [71:0]  out_tdata; // state_index, alpha_value, scale, zero pad
  logic         out_tuser; // scale_saturated
  logic         out_tlast; // last_of_column

  alpha_scoreboard sb;
  int burst_left;
  int items_done;
  int rx_mode;
  int rx_cnt;
  int cyc;

  hmm_forward_scaled_haploid_unit uut (.*);

  initial begin
    clk = 1'b0;
    forever #2 clk = ~clk;
  end

  // timeout watchdog
  initial cyc = 0;
  always @(posedge clk) begin
    cyc <= cyc + 1;
    if (cyc >= CYCLE_LIMIT) begin
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  // receiver: check accepted results, then pick the next stall decision
  initial begin
    rx_mode = 0;
    rx_cnt = 0;
  end
  always @(posedge clk) begin
    if (rst_n && out_tvalid && out_tready)
      sb.check_result(out_tdata[5:0], out_tdata[37:6], out_tdata[69:38],
                      out_tuser, out_tlast);
    rx_cnt <= rx_cnt + 1;
    if (rx_cnt % 150 == 0) rx_mode <= $urandom_range(0, 3);
    case (rx_mode)
      0: out_tready <= 1'b1;                            // no stalls
      1: out_tready <= ($urandom_range(0, 3) != 0);
      2: out_tready <= ($urandom_range(0, 3) == 0);     // heavy backpressure
      default: out_tready <= (rx_cnt % 8 < 5);          // periodic stall
    endcase
  end

  // Q1.31 field values: mostly in range, with the edges and over-range words
  function automatic bit [31:0] pick_q31();
    case ($urandom_range(0, 9))
      0: return 32'h0;
      1: return hmmf_pkg::ONE_Q31;
      2: return $urandom;
      3: return 32'hFFFF_FFFF;
      default: return $urandom_range(0, 32'h8000_0000);
    endcase
  endfunction

  // one item, sender in bursts; called at a rising edge
  task automatic send_item(bit [31:0] em, bit [31:0] rf, bit [31:0] st, bit [31:0] sw,
                           bit first, bit last);
    int gap;
    if (burst_left == 0) begin
      gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 12);
      if (gap > 0) begin
        in_tvalid <= 1'b0;
        repeat (gap) @(posedge clk);
      end
      burst_left = $urandom_range(1, 24);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {sw, st, rf, em};
    in_tuser  <= first;
    in_tlast  <= last;
    do @(posedge clk); while (!in_tready);
    if (!sb.ignores(first)) items_done++;
    sb.note_item(em, rf, st, sw, first, last);
    burst_left--;
  endtask

  // hold the sender until every expected item has come back
  task automatic drain();
    in_tvalid <= 1'b0;
    burst_left = 0;
    while (sb.pending_q.size() != 0) @(posedge clk);
  endtask

  task automatic write_reg(bit addr, bit val);
    drain();
    // an accepted item that closes no column may still be in flight without any result pending
    repeat (20) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_we    <= 1'b0;
    if (addr == hmmf_pkg::REG_START_MODE) sb.start_mode = val;
    else sb.first_only = val;
  endtask

  // one column of random content; noisy columns scramble the flags
  task automatic run_column(int len, bit first_col, bit noisy);
    bit f, l;
    int k;
    for (int i = 0; i < len; i++) begin
      f = noisy ? $urandom_range(0, 1) : first_col;
      l = noisy ? ($urandom_range(0, 5) == 0 || i == len - 1) : (i == len - 1);
      k = (sb.count >= sb.N) ? sb.N - 1 : sb.count;
      // never read a previous-column entry that was never written
      if (!f && sb.first_done && !sb.first_only && k >= sb.written_n) f = 1'b1;
      send_item(pick_q31(), pick_q31(), pick_q31(), pick_q31(), f, l);
    end
  endtask

  task automatic random_phase(int target);
    int len;
    bit fc;
    items_done = 0;
    while (items_done < target) begin
      fc = !sb.first_done || $urandom_range(0, 3) == 0;
      if (fc) begin
        case ($urandom_range(0, 9))
          0: len = $urandom_range(33, 36);  // longer than the state count
          1, 2: len = $urandom_range(9, 32);
          default: len = $urandom_range(1, 8);
        endcase
      end else begin
        len = $urandom_range(1, sb.written_n);
      end
      run_column(len, fc, $urandom_range(0, 9) == 0);
    end
  endtask

  initial begin
    sb = new();
    rst_n      <= 1'b0;
    cfg_we     <= 1'b0;
    cfg_addr   <= 1'b0;
    cfg_wdata  <= 1'b0;
    in_tvalid  <= 1'b0;
    in_tdata   <= '0;
    in_tuser   <= 1'b0;
    in_tlast   <= 1'b0;
    out_tready <= 1'b0;
    burst_left = 0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    write_reg(hmmf_pkg::REG_START_MODE, 1'b0);
    write_reg(hmmf_pkg::REG_FIRST_ONLY, 1'b0);

    // later column before any first column: previous values read as zero
    send_item(hmmf_pkg::ONE_Q31, hmmf_pkg::ONE_Q31, hmmf_pkg::ONE_Q31,
              hmmf_pkg::ONE_Q31, 1'b0, 1'b1);
    // zero column sum
    send_item(32'h0, hmmf_pkg::ONE_Q31, 32'h0, 32'h0, 1'b1, 1'b1);
    // over-range words clamp to one
    repeat (2)
      send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b0);
    send_item(32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 1'b1);
    // tiny sum saturates the scale
    send_item(hmmf_pkg::ONE_Q31, 32'd5, 32'h0, 32'h0, 1'b1, 1'b0);
    send_item(hmmf_pkg::ONE_Q31, 32'd3, 32'h0, 32'h0, 1'b1, 1'b1);
    // ordinary first column, then later columns with stay/switch extremes
    send_item(32'h4000_0000, 32'h2000_0000, 32'h0, 32'h0, 1'b1, 1'b0);
    send_item(32'h6000_0000, 32'h1000_0000, 32'h0, 32'h0, 1'b1, 1'b0);
    send_item(32'h7FFF_FFFF, 32'h3000_0000, 32'h0, 32'h0, 1'b1, 1'b1);
    send_item(hmmf_pkg::ONE_Q31, 32'h0, hmmf_pkg::ONE_Q31, 32'h0, 1'b0, 1'b0);
    send_item(32'h1234_5678, hmmf_pkg::ONE_Q31, 32'h0, hmmf_pkg::ONE_Q31, 1'b0, 1'b0);
    send_item(32'h0000_0001, hmmf_pkg::ONE_Q31, hmmf_pkg::ONE_Q31, hmmf_pkg::ONE_Q31,
              1'b0, 1'b1);
    // given start values, then first-column-only with an ignored item
    write_reg(hmmf_pkg::REG_START_MODE, 1'b1);
    send_item(32'h0, 32'h2000_0000, 32'h0, 32'h0, 1'b1, 1'b0);
    send_item(32'h0, 32'h6000_0000, 32'h0, 32'h0, 1'b1, 1'b1);
    write_reg(hmmf_pkg::REG_FIRST_ONLY, 1'b1);
    send_item(hmmf_pkg::ONE_Q31, hmmf_pkg::ONE_Q31, hmmf_pkg::ONE_Q31,
              hmmf_pkg::ONE_Q31, 1'b0, 1'b1);
    send_item(32'h0, hmmf_pkg::ONE_Q31, 32'h0, 32'h0, 1'b1, 1'b1);

    random_phase(110);
    write_reg(hmmf_pkg::REG_START_MODE, 1'b0);
    random_phase(110);
    write_reg(hmmf_pkg::REG_FIRST_ONLY, 1'b0);
    random_phase(60);
    drain();  // sender holds until the block has delivered everything
    random_phase(60);
    write_reg(hmmf_pkg::REG_START_MODE, 1'b1);
    random_phase(110);

    drain();
    repeat (300) @(posedge clk);
    if (sb.errors == 0 && sb.pending_q.size() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end
endmodule
